>>> hdl/jrd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jrd_pkg
// Shared types and constants of the joystick report decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package jrd_pkg;

  // configuration register indexes
  localparam int          CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DZ_EN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_DZ  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_DZ  = 3'd4;

  // divider shape: QUO_W quotient bits, DIV_STEPS bits per stage
  localparam int QUO_W      = 15;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = QUO_W / DIV_STEPS;

  localparam int SUM_W = 10;  // raw + offset, and all divisor candidates
  localparam int MAG_W = 9;   // magnitude of numerator, and positive divisor

  localparam logic signed [SUM_W-1:0] CENTRE = 10'sd128;
  localparam logic signed [15:0]      Q_MAX  = 16'sh7FFF;
  localparam logic signed [15:0]      Q_MIN  = 16'sh8000;

  typedef struct packed {
    logic [7:0] joy_x_byte;
    logic [7:0] joy_y_byte;
    logic [7:0] accel_x_byte;
    logic [7:0] accel_y_byte;
    logic [7:0] accel_z_byte;
    logic [7:0] extra_byte;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic signed [7:0]  stick_x_raw;
    logic signed [7:0]  stick_y_raw;
    logic               button_c;
    logic               button_z;
    logic [9:0]         accel_x;
    logic [9:0]         accel_y;
    logic [9:0]         accel_z;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [7:0]           wdata;
  } cfg_beat_t;

  typedef struct packed {
    logic              dz_en;
    logic signed [7:0] x_off;
    logic signed [7:0] y_off;
    logic [6:0]        x_dz;
    logic [6:0]        y_dz;
  } cfg_t;

  // fields that ride along the pipeline untouched
  typedef struct packed {
    logic signed [7:0] stick_x_raw;
    logic signed [7:0] stick_y_raw;
    logic              button_c;
    logic              button_z;
    logic [9:0]        accel_x;
    logic [9:0]        accel_y;
    logic [9:0]        accel_z;
  } side_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] den_off;
    logic signed [SUM_W-1:0] den_pos;
    logic signed [SUM_W-1:0] den_neg;
    logic [6:0]              dz;
  } axis_pre_t;

  typedef struct packed {
    logic      dz_en;
    axis_pre_t x;
    axis_pre_t y;
    side_t     side;
  } pre_beat_t;

  typedef struct packed {
    logic             neg;
    logic             sat;
    logic             zero;
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } axis_div_t;

  typedef struct packed {
    axis_div_t x;
    axis_div_t y;
    side_t     side;
  } div_beat_t;

endpackage

`default_nettype wire

>>> hdl/jrd_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jrd_if
// Valid/ready channels of the decoder: report in, result out, register write.
// ---------------------------------------------------------------------------
`default_nettype none

interface jrd_in_if;
  logic              valid;
  logic              ready;
  jrd_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface jrd_out_if;
  logic               valid;
  logic               ready;
  jrd_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface jrd_cfg_if;
  logic               valid;
  logic               ready;
  jrd_pkg::cfg_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/jrd_prep.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jrd_prep
// Two front stages: field decode and offset sums, then dead band selection,
// divider operands and saturation flags.
// ---------------------------------------------------------------------------
`default_nettype none

module jrd_prep (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire jrd_pkg::cfg_t       cfg,
  jrd_in_if.sink                   in_ch,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output jrd_pkg::div_beat_t       out_data
);

  function automatic jrd_pkg::axis_pre_t pre_axis(logic [7:0] joy, logic signed [7:0] off,
                                                  logic [6:0] dz);
    logic signed [jrd_pkg::SUM_W-1:0] raw10;
    logic signed [jrd_pkg::SUM_W-1:0] off10;
    logic signed [jrd_pkg::SUM_W-1:0] dz10;
    jrd_pkg::axis_pre_t               p;
    raw10     = {{3{~joy[7]}}, joy[6:0]};
    off10     = {{2{off[7]}}, off};
    dz10      = {3'b000, dz};
    p.sum     = raw10 + off10;
    p.den_off = jrd_pkg::CENTRE + off10;
    p.den_pos = jrd_pkg::CENTRE + off10 - dz10;
    p.den_neg = jrd_pkg::CENTRE - off10 - dz10;
    p.dz      = dz;
    return p;
  endfunction

  function automatic jrd_pkg::axis_div_t op_axis(jrd_pkg::axis_pre_t p, logic en);
    logic signed [jrd_pkg::SUM_W-1:0] dz10;
    logic signed [jrd_pkg::SUM_W-1:0] num;
    logic signed [jrd_pkg::SUM_W-1:0] den;
    logic [jrd_pkg::SUM_W-1:0]        mag;
    logic                             den_bad;
    jrd_pkg::axis_div_t               o;
    dz10 = {3'b000, p.dz};
    num  = p.sum;
    den  = p.den_off;
    if (en) begin
      if (p.sum > dz10) begin
        num = p.sum - dz10;
        den = p.den_pos;
      end else if (p.sum < -dz10) begin
        num = p.sum + dz10;
        den = p.den_neg;
      end else begin
        num = '0;
        den = p.den_pos;
      end
    end
    mag     = num[jrd_pkg::SUM_W-1] ? -num : num;
    den_bad = den[jrd_pkg::SUM_W-1] || (den == '0);
    o.neg   = num[jrd_pkg::SUM_W-1];
    o.zero  = (num == '0);
    // |q| reaches 2^15 exactly when |num| >= den
    o.sat   = den_bad || (mag >= den);
    o.rem   = mag[jrd_pkg::MAG_W-1:0];
    o.den   = den[jrd_pkg::MAG_W-1:0];
    o.quo   = '0;
    return o;
  endfunction

  jrd_pkg::pre_beat_t a_r;
  jrd_pkg::pre_beat_t a_nxt;
  logic               a_v_r;
  logic               a_ready;
  jrd_pkg::div_beat_t b_r;
  jrd_pkg::div_beat_t b_nxt;
  logic               b_v_r;
  logic               b_ready;

  assign b_ready     = !b_v_r || out_ready;
  assign a_ready     = !a_v_r || b_ready;
  assign in_ch.ready = a_ready;
  assign out_valid   = b_v_r;
  assign out_data    = b_r;

  always_comb begin
    a_nxt.dz_en            = cfg.dz_en;
    a_nxt.x                = pre_axis(in_ch.data.joy_x_byte, cfg.x_off, cfg.x_dz);
    a_nxt.y                = pre_axis(in_ch.data.joy_y_byte, cfg.y_off, cfg.y_dz);
    a_nxt.side.stick_x_raw = {~in_ch.data.joy_x_byte[7], in_ch.data.joy_x_byte[6:0]};
    a_nxt.side.stick_y_raw = {~in_ch.data.joy_y_byte[7], in_ch.data.joy_y_byte[6:0]};
    a_nxt.side.button_c    = ~in_ch.data.extra_byte[1];
    a_nxt.side.button_z    = ~in_ch.data.extra_byte[0];
    a_nxt.side.accel_x     = {in_ch.data.accel_x_byte, in_ch.data.extra_byte[3:2]};
    a_nxt.side.accel_y     = {in_ch.data.accel_y_byte, in_ch.data.extra_byte[5:4]};
    a_nxt.side.accel_z     = {in_ch.data.accel_z_byte, in_ch.data.extra_byte[7:6]};
  end

  always_comb begin
    b_nxt.x    = op_axis(a_r.x, a_r.dz_en);
    b_nxt.y    = op_axis(a_r.y, a_r.dz_en);
    b_nxt.side = a_r.side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_ready) a_v_r <= in_ch.valid;
      if (b_ready) b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_ch.valid) a_r <= a_nxt;
    if (b_ready && a_v_r)       b_r <= b_nxt;
  end

`ifndef NO_ASSERTIONS
  a_accept_lands : assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> a_v_r)
    else $error("accepted report did not reach first stage");

  a_div_ready : assert property (@(posedge clk) disable iff (!rst_n)
    (b_v_r && !b_r.x.sat && !b_r.y.sat) |-> (b_r.x.rem < b_r.x.den && b_r.y.rem < b_r.y.den))
    else $error("divider operands out of range without saturation");
`endif

endmodule

`default_nettype wire

>>> hdl/jrd_div_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jrd_div_stage
// One register stage of the restoring divider, a few quotient bits per axis.
// ---------------------------------------------------------------------------
`default_nettype none

module jrd_div_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire jrd_pkg::div_beat_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output jrd_pkg::div_beat_t      out_data
);

  function automatic jrd_pkg::axis_div_t div_bits(jrd_pkg::axis_div_t a);
    logic [jrd_pkg::MAG_W:0] r2;
    jrd_pkg::axis_div_t      o;
    o = a;
    for (int k = 0; k < jrd_pkg::DIV_STEPS; k++) begin
      r2 = {o.rem, 1'b0};
      if (r2 >= {1'b0, o.den}) begin
        r2    = r2 - {1'b0, o.den};
        o.quo = {o.quo[jrd_pkg::QUO_W-2:0], 1'b1};
      end else begin
        o.quo = {o.quo[jrd_pkg::QUO_W-2:0], 1'b0};
      end
      o.rem = r2[jrd_pkg::MAG_W-1:0];
    end
    return o;
  endfunction

  jrd_pkg::div_beat_t d_r;
  jrd_pkg::div_beat_t d_nxt;
  logic               v_r;

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = d_r;

  always_comb begin
    d_nxt.x    = div_bits(in_data.x);
    d_nxt.y    = div_bits(in_data.y);
    d_nxt.side = in_data.side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) d_r <= d_nxt;
  end

`ifndef NO_ASSERTIONS
  a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && !d_r.x.sat) |-> (d_r.x.rem < d_r.x.den))
    else $error("x partial remainder not below divisor");
`endif

endmodule

`default_nettype wire

>>> hdl/jrd_finish.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jrd_finish
// Output register: sign and saturation of the quotients, result beat.
// ---------------------------------------------------------------------------
`default_nettype none

module jrd_finish (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire jrd_pkg::div_beat_t in_data,
  jrd_out_if.source               out_ch
);

  function automatic logic signed [15:0] q15(jrd_pkg::axis_div_t a);
    logic signed [15:0] mag;
    logic signed [15:0] r;
    mag = {1'b0, a.quo};
    if (a.zero)     r = '0;
    else if (a.sat) r = a.neg ? jrd_pkg::Q_MIN : jrd_pkg::Q_MAX;
    else            r = a.neg ? -mag : mag;
    return r;
  endfunction

  jrd_pkg::out_beat_t o_r;
  jrd_pkg::out_beat_t o_nxt;
  logic               v_r;

  assign in_ready     = !v_r || out_ch.ready;
  assign out_ch.valid = v_r;
  assign out_ch.data  = o_r;

  always_comb begin
    o_nxt.stick_x     = q15(in_data.x);
    o_nxt.stick_y     = q15(in_data.y);
    o_nxt.stick_x_raw = in_data.side.stick_x_raw;
    o_nxt.stick_y_raw = in_data.side.stick_y_raw;
    o_nxt.button_c    = in_data.side.button_c;
    o_nxt.button_z    = in_data.side.button_z;
    o_nxt.accel_x     = in_data.side.accel_x;
    o_nxt.accel_y     = in_data.side.accel_y;
    o_nxt.accel_z     = in_data.side.accel_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) o_r <= o_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/joystick_report_decode_deadzone.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// joystick_report_decode_deadzone
// Controller report decoder with per-axis offset, dead band and Q1.15 scaling.
// ---------------------------------------------------------------------------
// Takes one report beat per clock while the output is not held off, and
// returns one result beat per report, in order, through two front stages
// (decode and offset sums, then dead band and divider operands), five
// stages of the restoring divider at three quotient bits each, and the output
// register. Each stage stalls only when it is full and the next one is too, so
// bubbles close up and reports keep entering while a result waits. Register
// writes are always accepted and should be issued only while no report is in
// flight.
`default_nettype none

module joystick_report_decode_deadzone (
  input  wire logic clk,
  input  wire logic rst_n,
  jrd_in_if.sink    in_ch,
  jrd_out_if.source out_ch,
  jrd_cfg_if.sink   cfg_ch
);

  jrd_pkg::cfg_t      cfg_r;
  logic               dv [jrd_pkg::DIV_STAGES+1];
  logic               dr [jrd_pkg::DIV_STAGES+1];
  jrd_pkg::div_beat_t dd [jrd_pkg::DIV_STAGES+1];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.reg_index)
        jrd_pkg::REG_DZ_EN: cfg_r.dz_en <= cfg_ch.data.wdata[0];
        jrd_pkg::REG_X_OFF: cfg_r.x_off <= cfg_ch.data.wdata;
        jrd_pkg::REG_Y_OFF: cfg_r.y_off <= cfg_ch.data.wdata;
        jrd_pkg::REG_X_DZ:  cfg_r.x_dz  <= cfg_ch.data.wdata[6:0];
        jrd_pkg::REG_Y_DZ:  cfg_r.y_dz  <= cfg_ch.data.wdata[6:0];
        default: ;
      endcase
    end
  end

  jrd_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .out_valid (dv[0]),
    .out_ready (dr[0]),
    .out_data  (dd[0])
  );

  for (genvar g = 0; g < jrd_pkg::DIV_STAGES; g++) begin : g_div
    jrd_div_stage u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv[g]),
      .in_ready  (dr[g]),
      .in_data   (dd[g]),
      .out_valid (dv[g+1]),
      .out_ready (dr[g+1]),
      .out_data  (dd[g+1])
    );
  end

  jrd_finish u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (dv[jrd_pkg::DIV_STAGES]),
    .in_ready (dr[jrd_pkg::DIV_STAGES]),
    .in_data  (dd[jrd_pkg::DIV_STAGES]),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the joystick report decoder. Report beats go in
// with random gaps, results are held off at random, and every result is
// compared field by field against an in-bench predictor. The predictor tracks
// the register writes: offsets, dead band and its enable. Corner cases come
// first, then randomized traffic under many register settings, then a long
// output hold-off that fills the pipeline.
// ---------------------------------------------------------------------------

module tb_top;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int Q_ONE        = 32768;
  localparam int MAX_REPORTED = 10;
  localparam int TAIL_CYCLES  = 24;
  localparam int HOLD_CYCLES  = 120;
  localparam int RUN_LIMIT_NS = 2_000_000;

  logic clk = 1'b0;
  logic rst_n;

  always #CLK_HALF clk = ~clk;

  jrd_in_if  in_ch ();
  jrd_out_if out_ch ();
  jrd_cfg_if cfg_ch ();

  joystick_report_decode_deadzone dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor copy of the registers, reset values
  bit model_dz_en = 1'b0;
  int model_x_off = 0;
  int model_y_off = 0;
  int model_x_dz  = 0;
  int model_y_dz  = 0;

  jrd_pkg::out_beat_t expected_q[$];

  int reports_sent;
  int results_seen;
  int mismatches;
  int settings_count;
  int dead_zeros;
  int sat_hits;

  int send_idle_pct;
  int recv_idle_pct;

  // hold-off request from the test sequence, counted down by the receiver
  int hold_len  = 0;
  bit hold_req  = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------
  function automatic logic signed [15:0] stick_scale(int raw, int off, int dz, bit dz_en);
    int s;
    int num;
    int den;
    int q;
    s = raw + off;
    if (dz_en) begin
      if (s > dz) begin
        num = s - dz;
        den = int'(jrd_pkg::CENTRE) + off - dz;
      end else if (s < -dz) begin
        num = s + dz;
        den = int'(jrd_pkg::CENTRE) - off - dz;
      end else begin
        return 16'sd0;
      end
    end else begin
      num = s;
      den = int'(jrd_pkg::CENTRE) + off;
    end
    if (den <= 0) begin
      // divisor gone: saturate by sign of numerator
      if (num > 0) q = int'(jrd_pkg::Q_MAX);
      else if (num < 0) q = int'(jrd_pkg::Q_MIN);
      else q = 0;
    end else begin
      q = (num * Q_ONE) / den;
      if (q > int'(jrd_pkg::Q_MAX)) q = int'(jrd_pkg::Q_MAX);
      if (q < int'(jrd_pkg::Q_MIN)) q = int'(jrd_pkg::Q_MIN);
    end
    return 16'(q);
  endfunction

  function automatic jrd_pkg::out_beat_t decode_report(jrd_pkg::in_beat_t r);
    jrd_pkg::out_beat_t o;
    int                 x_raw;
    int                 y_raw;
    x_raw         = int'(r.joy_x_byte) - int'(jrd_pkg::CENTRE);
    y_raw         = int'(r.joy_y_byte) - int'(jrd_pkg::CENTRE);
    o.stick_x     = stick_scale(x_raw, model_x_off, model_x_dz, model_dz_en);
    o.stick_y     = stick_scale(y_raw, model_y_off, model_y_dz, model_dz_en);
    o.stick_x_raw = 8'(x_raw);
    o.stick_y_raw = 8'(y_raw);
    o.button_c    = ~r.extra_byte[1];
    o.button_z    = ~r.extra_byte[0];
    o.accel_x     = {r.accel_x_byte, r.extra_byte[3:2]};
    o.accel_y     = {r.accel_y_byte, r.extra_byte[5:4]};
    o.accel_z     = {r.accel_z_byte, r.extra_byte[7:6]};
    return o;
  endfunction

  function automatic void latch_reg_write(jrd_pkg::cfg_beat_t w);
    case (w.reg_index)
      jrd_pkg::REG_DZ_EN: model_dz_en = w.wdata[0];
      jrd_pkg::REG_X_OFF: model_x_off = int'($signed(w.wdata));
      jrd_pkg::REG_Y_OFF: model_y_off = int'($signed(w.wdata));
      jrd_pkg::REG_X_DZ:  model_x_dz  = int'(w.wdata[6:0]);
      jrd_pkg::REG_Y_DZ:  model_y_dz  = int'(w.wdata[6:0]);
      default: ;  // unused index, dropped
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTED)
        $display("%0t: %s mismatch: expected 0x%h, got 0x%h", $time, name, exp_v, act_v);
    end
  endfunction

  // ------------------------------------------------------------------------
  // scoreboard: register writes, report beats in, result beats out
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    jrd_pkg::out_beat_t exp_r;
    jrd_pkg::out_beat_t pred;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) latch_reg_write(cfg_ch.data);

      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED)
            $display("%0t: result beat with nothing pending: 0x%h", $time, out_ch.data);
        end else begin
          exp_r = expected_q.pop_front();
          check_field("stick_x",     exp_r.stick_x,     out_ch.data.stick_x);
          check_field("stick_y",     exp_r.stick_y,     out_ch.data.stick_y);
          check_field("stick_x_raw", exp_r.stick_x_raw, out_ch.data.stick_x_raw);
          check_field("stick_y_raw", exp_r.stick_y_raw, out_ch.data.stick_y_raw);
          check_field("button_c",    exp_r.button_c,    out_ch.data.button_c);
          check_field("button_z",    exp_r.button_z,    out_ch.data.button_z);
          check_field("accel_x",     exp_r.accel_x,     out_ch.data.accel_x);
          check_field("accel_y",     exp_r.accel_y,     out_ch.data.accel_y);
          check_field("accel_z",     exp_r.accel_z,     out_ch.data.accel_z);
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        pred = decode_report(in_ch.data);
        expected_q.push_back(pred);
        if (model_dz_en && (pred.stick_x == 16'sd0 || pred.stick_y == 16'sd0)) dead_zeros++;
        if (pred.stick_x == jrd_pkg::Q_MAX || pred.stick_x == jrd_pkg::Q_MIN ||
            pred.stick_y == jrd_pkg::Q_MAX || pred.stick_y == jrd_pkg::Q_MIN) sat_hits++;
      end
    end
  end

  // result side: random stalls plus requested long hold-off
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ------------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------------
  task automatic send_report(input jrd_pkg::in_beat_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    reports_sent++;
  endtask

  // drop valid in the step of the last beat, then wait out the pipeline
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (results_seen < reports_sent) @(posedge clk);
  endtask

  // full register set; unused upper bits and an out-of-range index get junk
  task automatic write_settings(bit en, int xo, int yo, int xdz, int ydz);
    jrd_pkg::cfg_beat_t w[6];
    w[0].reg_index = jrd_pkg::CFG_IDX_W'(jrd_pkg::REG_Y_DZ + 1 + $urandom_range(2));
    w[0].wdata     = 8'($urandom_range(255));
    w[1].reg_index = jrd_pkg::REG_DZ_EN;
    w[1].wdata     = {7'($urandom_range(127)), en};
    w[2].reg_index = jrd_pkg::REG_X_OFF;
    w[2].wdata     = 8'(xo);
    w[3].reg_index = jrd_pkg::REG_Y_OFF;
    w[3].wdata     = 8'(yo);
    w[4].reg_index = jrd_pkg::REG_X_DZ;
    w[4].wdata     = {1'($urandom_range(1)), 7'(xdz)};
    w[5].reg_index = jrd_pkg::REG_Y_DZ;
    w[5].wdata     = {1'($urandom_range(1)), 7'(ydz)};
    for (int i = 0; i < 6; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.data  <= w[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    settings_count++;
  endtask

  function automatic int pick_offset();
    case ($urandom_range(9))
      0:       return -128;
      1:       return 127;
      2:       return 0;
      default: return int'($urandom_range(255)) - 128;
    endcase
  endfunction

  function automatic int pick_deadzone();
    case ($urandom_range(9))
      0:         return 0;
      1:         return 127;
      2, 3, 4:   return int'($urandom_range(127));
      default:   return int'($urandom_range(24));
    endcase
  endfunction

  // stick byte around the calibrated centre, straddling the dead band edges
  function automatic logic [7:0] near_centre(int off, int dz);
    int v;
    v = int'(jrd_pkg::CENTRE) - off - dz - 3 + int'($urandom_range(2 * dz + 6));
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic jrd_pkg::in_beat_t random_report();
    jrd_pkg::in_beat_t r;
    r.joy_x_byte   = 8'($urandom_range(255));
    r.joy_y_byte   = 8'($urandom_range(255));
    r.accel_x_byte = 8'($urandom_range(255));
    r.accel_y_byte = 8'($urandom_range(255));
    r.accel_z_byte = 8'($urandom_range(255));
    r.extra_byte   = 8'($urandom_range(255));
    if ($urandom_range(99) < 35) r.joy_x_byte = near_centre(model_x_off, model_x_dz);
    if ($urandom_range(99) < 35) r.joy_y_byte = near_centre(model_y_off, model_y_dz);
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  // reset register values: plain scaling, no offsets
  task automatic test_decode_at_reset();
    send_report('{8'd0,   8'd255, 8'h00, 8'hFF, 8'h00, 8'h00});
    send_report('{8'd255, 8'd0,   8'hFF, 8'h00, 8'hFF, 8'hFF});
    send_report('{8'd128, 8'd128, 8'h55, 8'hAA, 8'h5A, 8'h55});
    send_report('{8'd127, 8'd129, 8'hAA, 8'h55, 8'hA5, 8'hAA});
    send_report('{8'd1,   8'd254, 8'h80, 8'h01, 8'h7F, 8'h0C});
    wait_drained();
  endtask

  task automatic test_scaling_corners();
    // divisor of zero on x, widest divisor on y
    write_settings(1'b0, -128, 127, 0, 0);
    send_report('{8'd0,   8'd127, 8'h12, 8'h34, 8'h56, 8'h30});
    send_report('{8'd255, 8'd255, 8'h9A, 8'hBC, 8'hDE, 8'hC0});
    send_report('{8'd128, 8'd0,   8'h00, 8'h00, 8'h00, 8'h03});
    send_report('{8'd200, 8'd1,   8'hFF, 8'hFF, 8'hFF, 8'hFC});
    wait_drained();

    // widest dead band on x, most negative offset on y
    write_settings(1'b1, 0, -128, 127, 0);
    send_report('{8'd0,   8'd0,   8'h01, 8'h02, 8'h03, 8'h01});
    send_report('{8'd1,   8'd128, 8'h04, 8'h05, 8'h06, 8'h02});
    send_report('{8'd255, 8'd255, 8'h07, 8'h08, 8'h09, 8'hF0});
    send_report('{8'd128, 8'd127, 8'h0A, 8'h0B, 8'h0C, 8'h0F});
    wait_drained();

    // negative offset without dead band: quotient runs out of range
    write_settings(1'b0, -100, 0, 0, 0);
    send_report('{8'd0,   8'd0,   8'hC3, 8'h3C, 8'h81, 8'h99});
    send_report('{8'd255, 8'd255, 8'h18, 8'h24, 8'h42, 8'h66});
    send_report('{8'd27,  8'd128, 8'hE7, 8'h7E, 8'hDB, 8'hBD});
    wait_drained();

    // moderate band: stick just inside and just outside each edge
    write_settings(1'b1, 5, -7, 10, 3);
    send_report('{8'd133, 8'd138, 8'h11, 8'h22, 8'h33, 8'h44});
    send_report('{8'd134, 8'd139, 8'h55, 8'h66, 8'h77, 8'h88});
    send_report('{8'd113, 8'd132, 8'h99, 8'hAA, 8'hBB, 8'hCC});
    send_report('{8'd112, 8'd131, 8'hDD, 8'hEE, 8'hFF, 8'h00});
    send_report('{8'd123, 8'd135, 8'h01, 8'h10, 8'h80, 8'h08});
    wait_drained();
  endtask

  task automatic test_random_traffic(int n_items, int n_settings);
    for (int s = 0; s < n_settings; s++) begin
      write_settings(1'($urandom_range(1)), pick_offset(), pick_offset(),
                     pick_deadzone(), pick_deadzone());
      for (int i = 0; i < n_items / n_settings; i++) send_report(random_report());
      wait_drained();
    end
  endtask

  // long result hold-off while reports keep coming, then a full pause
  task automatic test_backpressure();
    write_settings(1'b1, pick_offset(), pick_offset(), pick_deadzone(), pick_deadzone());
    hold_len = HOLD_CYCLES;
    hold_req = ~hold_req;
    for (int i = 0; i < 60; i++) send_report(random_report());
    wait_drained();
    for (int i = 0; i < 20; i++) send_report(random_report());
    wait_drained();
  endtask

  // ------------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------------
  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    send_idle_pct = 28;
    recv_idle_pct = 54;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_decode_at_reset();
    test_scaling_corners();
    test_random_traffic(420, 5);

    send_idle_pct = 54;
    recv_idle_pct = 28;
    test_random_traffic(420, 5);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(420, 5);
    test_backpressure();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d reports over %0d register settings, with output hold-off",
             reports_sent, settings_count);
    $display("Dead band zero results: %0d, saturated results: %0d, field mismatches: %0d",
             dead_zeros, sat_hits, mismatches);
    if (mismatches == 0 && results_seen == reports_sent && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout: %0d reports sent, %0d results seen", reports_sent, results_seen);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> filelist.f
hdl/jrd_pkg.sv
hdl/jrd_if.sv
hdl/jrd_prep.sv
hdl/jrd_div_stage.sv
hdl/jrd_finish.sv
hdl/joystick_report_decode_deadzone.sv
test/tb_top.sv
